/* rtl/cbba_pkg.sv */
// Shared types and codes for the contiguous bitmap block allocator.
// Standalone package; used by the top level by scoped names.
`default_nettype none
package cbba_pkg;
  // map size; the field widths of the ports are sized for it
  localparam int unsigned NUM_BLOCKS = 8192;

  typedef enum logic [1:0] {
    FUNC_FORMAT = 2'd0,
    FUNC_ALLOC  = 2'd1,
    FUNC_FREE   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NORUN   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMT,
    S_SRCH_RD,
    S_SRCH,
    S_MARK_RD,
    S_MARK,
    S_CHK_RD,
    S_CHK,
    S_RESP
  } state_t;
endpackage
`default_nettype wire

/* rtl/contiguous_bitmap_block_allocator.sv */
// First-fit contiguous block allocator: top level with the bitmap memory.
// Depends on cbba_pkg (map size, codes and state type).
`default_nettype none
// The free-block bitmap is held in a 32-bit-wide synchronous memory, one bit per block
// (1 = free). Every transaction is accepted in idle and loads its result in a response
// state. Format rewrites every word. An allocate is rejected up front if it is of zero
// length or asks for more than the free count. Otherwise it scans from first_block one
// bit per cycle, pausing for a read of every word it enters, up to the end of the run
// found or the end of the map, then clears the run with a read-modify-write per block.
// Free checks the run with a read per block, stopping at the first block already free,
// and then sets it with a read-modify-write per block. The bit-serial run tracking and
// the single memory port set the pace of each operation. After reset the block runs a
// format pass over every word before it takes the first transaction.
// Results sit in an output register until taken; a new result waits while the previous
// one is still held.
module contiguous_bitmap_block_allocator (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [12:0]                 cfg_wdata,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [1:0]                  in_func,
  input  wire  [13:0]                 in_block_count,
  input  wire  [12:0]                 in_start_block,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [1:0]                  out_status,
  output logic [12:0]                 out_run_start,
  output logic [13:0]                 out_free_left
);
  localparam int unsigned NUM_BLOCKS = cbba_pkg::NUM_BLOCKS;
  localparam int unsigned BW = $clog2(NUM_BLOCKS) + 1; // holds NUM_BLOCKS itself
  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned WORDS = (NUM_BLOCKS + 31) / 32;
  localparam int unsigned WW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [BW-1:0] NB = BW'(NUM_BLOCKS);

  cbba_pkg::state_t state_r, state_nxt;

  logic [31:0] mem [WORDS];
  logic [31:0] rd_data_r;
  logic        mem_we;
  logic [WW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  logic [12:0] first_block_r;
  logic [13:0] free_total_r, free_total_nxt;
  logic [BW-1:0] idx_r, idx_nxt;     // current block
  logic [BW-1:0] end_r, end_nxt;     // one past last block of run
  logic [BW-1:0] run_r, run_nxt;
  logic [BW-1:0] rs_r, rs_nxt;       // run start
  logic [13:0] n_r, n_nxt;
  logic [1:0]  func_r, func_nxt;
  logic        set_r, set_nxt;       // mark value
  logic [1:0]  st_r, st_nxt;
  logic [12:0] ores_r, ores_nxt;
  logic        ov_r;
  logic [BW:0] sb_end;
  logic        bit_v;
  logic [14:0] sum_free;

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  assign bit_v   = rd_data_r[idx_r[4:0]];
  assign sb_end  = {1'b0, BW'(in_start_block)} + (BW+1)'(in_block_count);
  assign sum_free = {1'b0, free_total_r} + {1'b0, n_r};

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbba_pkg::S_IDLE: begin
        if (in_valid) begin
          case (cbba_pkg::func_t'(in_func))
            cbba_pkg::FUNC_FORMAT: state_nxt = cbba_pkg::S_FMT;
            cbba_pkg::FUNC_ALLOC: begin
              if (in_block_count == 14'd0 || in_block_count > free_total_r ||
                  {1'b0, first_block_r} >= 14'(NUM_BLOCKS))
                state_nxt = cbba_pkg::S_RESP;
              else state_nxt = cbba_pkg::S_SRCH_RD;
            end
            cbba_pkg::FUNC_FREE: begin
              if (in_block_count == 14'd0 || sb_end > (BW+1)'(NUM_BLOCKS))
                state_nxt = cbba_pkg::S_RESP;
              else state_nxt = cbba_pkg::S_CHK_RD;
            end
            default: state_nxt = cbba_pkg::S_RESP;
          endcase
        end
      end
      cbba_pkg::S_FMT:
        if (idx_r[AW:5] == (AW-4)'(WORDS - 1) || WORDS == 1) state_nxt = cbba_pkg::S_RESP;
      cbba_pkg::S_SRCH_RD: state_nxt = cbba_pkg::S_SRCH;
      cbba_pkg::S_SRCH: begin
        if (bit_v && run_nxt == BW'(n_r)) state_nxt = cbba_pkg::S_MARK_RD;
        else if (idx_r == NB - 1'b1) state_nxt = cbba_pkg::S_RESP;
        else if (idx_r[4:0] == 5'd31) state_nxt = cbba_pkg::S_SRCH_RD;
      end
      cbba_pkg::S_MARK_RD: state_nxt = cbba_pkg::S_MARK;
      cbba_pkg::S_MARK:
        state_nxt = (idx_r + 1'b1 == end_r) ? cbba_pkg::S_RESP : cbba_pkg::S_MARK_RD;
      cbba_pkg::S_CHK_RD: state_nxt = cbba_pkg::S_CHK;
      cbba_pkg::S_CHK: begin
        if (bit_v) state_nxt = cbba_pkg::S_RESP;
        else if (idx_r + 1'b1 == end_r) state_nxt = cbba_pkg::S_MARK_RD;
        else state_nxt = cbba_pkg::S_CHK_RD;
      end
      cbba_pkg::S_RESP: if (!ov_r || out_ready) state_nxt = cbba_pkg::S_IDLE;
      default: state_nxt = cbba_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    idx_nxt = idx_r; end_nxt = end_r; run_nxt = run_r; rs_nxt = rs_r;
    n_nxt = n_r; func_nxt = func_r; set_nxt = set_r; st_nxt = st_r;
    ores_nxt = ores_r; free_total_nxt = free_total_r;
    mem_we = 1'b0; mem_waddr = idx_r[AW-1:5]; mem_raddr = idx_r[AW-1:5];
    mem_wdata = rd_data_r;
    in_ready = 1'b0;
    case (state_r)
      cbba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          n_nxt = in_block_count; func_nxt = in_func; run_nxt = '0;
          ores_nxt = '0; st_nxt = cbba_pkg::ST_OK;
          case (cbba_pkg::func_t'(in_func))
            cbba_pkg::FUNC_FORMAT: idx_nxt = '0;
            cbba_pkg::FUNC_ALLOC: begin
              idx_nxt = BW'(first_block_r); set_nxt = 1'b0;
              if (in_block_count == 14'd0) st_nxt = cbba_pkg::ST_INVALID;
              else if (in_block_count > free_total_r) st_nxt = cbba_pkg::ST_NOSPACE;
              else st_nxt = cbba_pkg::ST_NORUN;
            end
            cbba_pkg::FUNC_FREE: begin
              idx_nxt = BW'(in_start_block); rs_nxt = BW'(in_start_block);
              end_nxt = sb_end[BW-1:0]; set_nxt = 1'b1;
              if (in_block_count == 14'd0 || sb_end > (BW+1)'(NUM_BLOCKS))
                st_nxt = cbba_pkg::ST_INVALID;
            end
            default: st_nxt = cbba_pkg::ST_INVALID;
          endcase
        end
      end
      cbba_pkg::S_FMT: begin
        mem_we = 1'b1; mem_wdata = '1;
        idx_nxt = idx_r + BW'(32);
        if (idx_r[AW:5] == (AW-4)'(WORDS - 1) || WORDS == 1)
          free_total_nxt = ({1'b0, first_block_r} < 14'(NUM_BLOCKS)) ?
                           14'(NUM_BLOCKS) - {1'b0, first_block_r} : 14'd0;
      end
      cbba_pkg::S_SRCH: begin
        run_nxt = bit_v ? run_r + 1'b1 : '0;
        idx_nxt = idx_r + 1'b1;
        if (bit_v && run_nxt == BW'(n_r)) begin
          rs_nxt = idx_r + 1'b1 - BW'(n_r);
          idx_nxt = idx_r + 1'b1 - BW'(n_r);
          end_nxt = idx_r + 1'b1;
          ores_nxt = 13'(idx_r + 1'b1 - BW'(n_r));
          st_nxt = cbba_pkg::ST_OK;
        end
      end
      cbba_pkg::S_MARK: begin
        mem_we = 1'b1;
        mem_wdata[idx_r[4:0]] = set_r;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == end_r) begin
          if (set_r) free_total_nxt = (sum_free > 15'(NUM_BLOCKS)) ?
                                      14'(NUM_BLOCKS) : sum_free[13:0];
          else free_total_nxt = free_total_r - n_r;
        end
      end
      cbba_pkg::S_CHK: begin
        idx_nxt = idx_r + 1'b1;
        if (bit_v) st_nxt = cbba_pkg::ST_INVALID;
        else if (idx_r + 1'b1 == end_r) idx_nxt = rs_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbba_pkg::S_FMT;
      first_block_r <= 13'd400;
      idx_r <= '0;
      ov_r <= 1'b0;
      free_total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) first_block_r <= cfg_wdata;
      idx_r <= idx_nxt;
      free_total_r <= free_total_nxt;
      // reset-time format leaves no pending result
      if (state_r == cbba_pkg::S_RESP && (!ov_r || out_ready) &&
          !(func_r == cbba_pkg::FUNC_FORMAT && st_r == cbba_pkg::ST_NOSPACE))
        ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    end_r <= end_nxt; run_r <= run_nxt; rs_r <= rs_nxt; n_r <= n_nxt;
    set_r <= set_nxt; ores_r <= ores_nxt;
    if (!rst_n) begin
      // a format carrying this status can only be the reset format
      func_r <= cbba_pkg::FUNC_FORMAT; st_r <= cbba_pkg::ST_NOSPACE;
    end else begin
      func_r <= func_nxt;
      st_r <= st_nxt;
    end
    if (state_r == cbba_pkg::S_RESP && (!ov_r || out_ready)) begin
      out_status    <= (func_r == cbba_pkg::FUNC_FORMAT) ? cbba_pkg::ST_OK : st_r;
      out_run_start <= (st_r == cbba_pkg::ST_OK && func_r == cbba_pkg::FUNC_ALLOC) ?
                       ores_r : 13'd0;
      out_free_left <= free_total_r;
    end
  end

  assign out_valid = ov_r;

  // Assertions
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == cbba_pkg::S_IDLE) else $error("ready outside idle");
  a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= 14'(NUM_BLOCKS)) else $error("free count overflow");
  a_ok_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cbba_pkg::ST_OK |-> out_run_start == 13'd0)
    else $error("run start on failure");
endmodule
`default_nettype wire
